/* rtl/voxel_layer_compactor_macros.svh */
// Assertion macros shared by the voxel layer compactor RTL.
// No dependencies; included by the files that carry assertions.
`ifndef VOXEL_LAYER_COMPACTOR_MACROS_SVH
`define VOXEL_LAYER_COMPACTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset
`define VLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vlc assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset
`define VLC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vlc assertion failed");
`else
`define VLC_ASSERT_IMP(lbl, ante, cons)
`define VLC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/vlc_pkg.sv */
// Shared types, codes and constants of the voxel layer compactor.
// No dependencies; imported by every module of the block.
`default_nettype none

package vlc_pkg;

  // Default edge length of the cubic chunk
  localparam int VLC_CHUNK_EDGE_DEF = 4;
  // Voxels per group and bits of the in-group position
  localparam int VLC_GROUP_SIZE = 8;
  localparam int VLC_GROUP_BITS = 3;
  // Mask, pointer and child-count widths
  localparam int VLC_MASK_W  = 8;
  localparam int VLC_PTR_W   = 8;
  localparam int VLC_GCNT_W  = 4;
  localparam int VLC_VOXEL_W = 8;
  localparam int VLC_WORD_W  = 16;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_LOADED = 2'd1,
    STATUS_EMPTY      = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_REPLY = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    fetch;
    logic    reply;
    status_e code;
  } vlc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic loaded;
    logic has_parents;
  } vlc_stat_t;

  // Address width of a store, at least one bit
  function automatic int vlc_addr_w(input int depth);
    int w;
    w = (depth > 1) ? $clog2(depth) : 1;
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/voxel_layer_compactor.sv */
// Top level of the voxel layer compactor: controller plus datapath.
// Depends on vlc_pkg, vlc_ctrl, vlc_datapath (and through it vlc_ram).
`default_nettype none

// Builds one sparse-octree layer from a dense chunk of CHUNK_EDGE^3 voxel
// bytes. A transaction is taken on a rising edge with start high and busy
// low; func_i selects load (0) or read (1). A load is absorbed in the
// accepting cycle, busy stays low and loads may arrive every cycle. A read
// raises busy in the cycle after the accepting edge, while the
// registered read data of the child and parent stores is turned into the
// result. The result is on word_o, last_o and status_o with result_valid_o
// high for exactly the following cycle, and is taken at the edge that ends
// that cycle; a new transaction can be accepted at that same edge, but not
// while busy is high. Results cannot be held off: capture them
// while result_valid_o is high. Reads before the chunk is fully loaded return
// status 1, reads of an empty chunk status 2.
module voxel_layer_compactor
  import vlc_pkg::*;
#(
  parameter int CHUNK_EDGE = VLC_CHUNK_EDGE_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   func_i,
  input  wire logic [VLC_VOXEL_W-1:0] voxel_i,
  output logic                        result_valid_o,
  output logic      [VLC_WORD_W-1:0]  word_o,
  output logic                        last_o,
  output logic      [1:0]             status_o
);

  vlc_cmd_t  cmd;
  vlc_stat_t stat;

  // Sequence transactions
  vlc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // Counters, stores and result registers
  vlc_datapath #(
    .CHUNK_EDGE (CHUNK_EDGE)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .voxel_i  (voxel_i),
    .stat_o   (stat),
    .valid_o  (result_valid_o),
    .word_o   (word_o),
    .last_o   (last_o),
    .status_o (status_o)
  );

endmodule

`default_nettype wire

/* rtl/vlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on vlc_pkg for the address width helper.
`default_nettype none

module vlc_ram
  import vlc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [vlc_addr_w(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]             wdata_i,
  input  wire logic                         re_i,
  input  wire logic [vlc_addr_w(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/vlc_ctrl.sv */
// Controller of the voxel layer compactor: accepts transactions, sequences reads.
// Depends on vlc_pkg and voxel_layer_compactor_macros.svh.
`default_nettype none
`include "voxel_layer_compactor_macros.svh"

module vlc_ctrl
  import vlc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      func_i,
  input  wire vlc_stat_t stat_i,
  output logic           busy_o,
  output vlc_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (func_e'(func_i) == FUNC_READ)) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '{load: 1'b0, fetch: 1'b0, reply: 1'b0, code: STATUS_OK};
    case (state_q)
      ST_IDLE: begin
        cmd_o.load  = accept && (func_e'(func_i) == FUNC_LOAD);
        cmd_o.fetch = accept && (func_e'(func_i) == FUNC_READ);
      end
      ST_REPLY: begin
        cmd_o.reply = 1'b1;
        if (!stat_i.loaded) begin
          cmd_o.code = STATUS_NOT_LOADED;
        end else if (!stat_i.has_parents) begin
          cmd_o.code = STATUS_EMPTY;
        end else begin
          cmd_o.code = STATUS_OK;
        end
      end
      default: begin
        cmd_o.reply = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A read transaction is answered in the following cycle
  `VLC_ASSERT_NXT(a_read_replies, cmd_o.fetch, cmd_o.reply)
  // A reply lasts one cycle only
  `VLC_ASSERT_NXT(a_reply_single, cmd_o.reply, !busy_o)
  // Loads never stall the input side
  `VLC_ASSERT_NXT(a_load_no_stall, cmd_o.load, !busy_o)

endmodule

`default_nettype wire

/* rtl/vlc_datapath.sv */
// Datapath of the voxel layer compactor: counters, child and parent stores,
// parent word assembly and result registers.
// Depends on vlc_pkg, vlc_ram and voxel_layer_compactor_macros.svh.
`default_nettype none
`include "voxel_layer_compactor_macros.svh"

module vlc_datapath
  import vlc_pkg::*;
#(
  parameter int CHUNK_EDGE = VLC_CHUNK_EDGE_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire vlc_cmd_t               cmd_i,
  input  wire logic [VLC_VOXEL_W-1:0] voxel_i,
  output vlc_stat_t                   stat_o,
  output logic                        valid_o,
  output logic      [VLC_WORD_W-1:0]  word_o,
  output logic                        last_o,
  output logic      [1:0]             status_o
);

  localparam int VOXEL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int GROUP_COUNT = (VOXEL_COUNT + VLC_GROUP_SIZE - 1) / VLC_GROUP_SIZE;
  localparam int VIDX_W = $clog2(VOXEL_COUNT + 1);
  localparam int CTOT_W = $clog2(VOXEL_COUNT + 1);
  localparam int PTOT_W = $clog2(GROUP_COUNT + 1);
  localparam int RIDX_W = $clog2(GROUP_COUNT + VOXEL_COUNT + 1);
  localparam int CAW    = vlc_addr_w(VOXEL_COUNT);
  localparam int PAW    = vlc_addr_w(GROUP_COUNT);
  localparam int PENT_W = VLC_GCNT_W + VLC_MASK_W;

  // Running state
  logic [VIDX_W-1:0]     vidx_q, vidx_d;
  logic [CTOT_W-1:0]     ctot_q, ctot_d;
  logic [PTOT_W-1:0]     ptot_q, ptot_d;
  logic [VLC_MASK_W-1:0] gmask_q, gmask_d;
  logic [VLC_GCNT_W-1:0] gcnt_q, gcnt_d;
  logic [RIDX_W-1:0]     ridx_q, ridx_d;
  logic [VLC_PTR_W-1:0]  pacc_q, pacc_d;

  // Result registers
  logic                  valid_q;
  logic [VLC_WORD_W-1:0] word_q, word_d;
  logic                  last_q, last_d;
  status_e               status_q;

  // Load path
  logic                      loaded, fresh, nz, close;
  logic [VIDX_W-1:0]         vidx_eff;
  logic [CTOT_W-1:0]         ctot_eff;
  logic [PTOT_W-1:0]         ptot_eff;
  logic [VLC_MASK_W-1:0]     mask_new;
  logic [VLC_GCNT_W-1:0]     cnt_new;
  logic [VLC_GROUP_BITS-1:0] bit_sel;
  logic                      child_we, par_we;

  // Read path
  logic [RIDX_W-1:0]      child_off, total, ridx_inc;
  logic                   is_parent, is_last;
  logic [VLC_VOXEL_W-1:0] child_rdata;
  logic [PENT_W-1:0]      par_rdata;
  logic [VLC_PTR_W-1:0]   ptr;

  assign loaded = (vidx_q == VIDX_W'(VOXEL_COUNT));
  assign stat_o = '{loaded: loaded, has_parents: (ptot_q != '0)};

  // A load after a complete chunk starts a new chunk from cleared counters
  assign fresh    = loaded;
  assign vidx_eff = fresh ? '0 : vidx_q;
  assign ctot_eff = fresh ? '0 : ctot_q;
  assign ptot_eff = fresh ? '0 : ptot_q;
  assign nz       = (voxel_i != '0);
  assign bit_sel  = vidx_eff[VLC_GROUP_BITS-1:0];

  // Fold the voxel into the open group
  always_comb begin
    mask_new = fresh ? '0 : gmask_q;
    cnt_new  = fresh ? '0 : gcnt_q;
    if (nz) begin
      mask_new = mask_new | (VLC_MASK_W'(1) << bit_sel);
      cnt_new  = cnt_new + VLC_GCNT_W'(1);
    end
  end

  // Close the group on its eighth voxel or on the chunk's last voxel
  assign close    = (bit_sel == {VLC_GROUP_BITS{1'b1}}) ||
                    (vidx_eff == VIDX_W'(VOXEL_COUNT - 1));
  assign child_we = cmd_i.load && nz;
  assign par_we   = cmd_i.load && close && (mask_new != '0);

  // Read addresses: parent slot or child slot of the current read position
  assign child_off = ridx_q - RIDX_W'(ptot_q);

  vlc_ram #(
    .WIDTH (VLC_VOXEL_W),
    .DEPTH (VOXEL_COUNT)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (ctot_eff[CAW-1:0]),
    .wdata_i (voxel_i),
    .re_i    (cmd_i.fetch),
    .raddr_i (child_off[CAW-1:0]),
    .rdata_o (child_rdata)
  );

  vlc_ram #(
    .WIDTH (PENT_W),
    .DEPTH (GROUP_COUNT)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (ptot_eff[PAW-1:0]),
    .wdata_i ({cnt_new, mask_new}),
    .re_i    (cmd_i.fetch),
    .raddr_i (ridx_q[PAW-1:0]),
    .rdata_o (par_rdata)
  );

  // Assemble the outgoing word
  assign total     = RIDX_W'(ptot_q) + RIDX_W'(ctot_q);
  assign ridx_inc  = ridx_q + RIDX_W'(1);
  assign is_parent = (ridx_q < RIDX_W'(ptot_q));
  assign is_last   = (ridx_inc == total);
  assign ptr       = VLC_PTR_W'(ptot_q) + pacc_q;

  // Next state of counters and result
  always_comb begin
    vidx_d  = vidx_q;
    ctot_d  = ctot_q;
    ptot_d  = ptot_q;
    gmask_d = gmask_q;
    gcnt_d  = gcnt_q;
    ridx_d  = ridx_q;
    pacc_d  = pacc_q;
    word_d  = '0;
    last_d  = 1'b0;
    if (cmd_i.load) begin
      vidx_d  = vidx_eff + VIDX_W'(1);
      ctot_d  = ctot_eff + CTOT_W'(nz);
      ptot_d  = ptot_eff + PTOT_W'(par_we);
      gmask_d = close ? '0 : mask_new;
      gcnt_d  = close ? '0 : cnt_new;
      ridx_d  = fresh ? '0 : ridx_q;
      pacc_d  = fresh ? '0 : pacc_q;
    end
    if (cmd_i.reply && (cmd_i.code == STATUS_OK)) begin
      last_d = is_last;
      if (is_parent) begin
        word_d = {ptr, par_rdata[VLC_MASK_W-1:0]};
        pacc_d = pacc_q + VLC_PTR_W'(par_rdata[PENT_W-1:VLC_MASK_W]);
      end else begin
        word_d = {{(VLC_WORD_W-VLC_VOXEL_W){1'b0}}, child_rdata};
      end
      // Wrap to the first parent word after the final word
      ridx_d = is_last ? '0 : ridx_inc;
      if (is_last) begin
        pacc_d = '0;
      end
    end
  end

  // Control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vidx_q  <= '0;
      ctot_q  <= '0;
      ptot_q  <= '0;
      gmask_q <= '0;
      gcnt_q  <= '0;
      ridx_q  <= '0;
      pacc_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      vidx_q  <= vidx_d;
      ctot_q  <= ctot_d;
      ptot_q  <= ptot_d;
      gmask_q <= gmask_d;
      gcnt_q  <= gcnt_d;
      ridx_q  <= ridx_d;
      pacc_q  <= pacc_d;
      valid_q <= cmd_i.reply;
    end
  end

  // Result payload, held until the next reply
  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      word_q   <= word_d;
      last_q   <= last_d;
      status_q <= cmd_i.code;
    end
  end

  assign valid_o  = valid_q;
  assign word_o   = word_q;
  assign last_o   = last_q;
  assign status_o = status_q;

  // Every reply shows exactly one result strobe
  `VLC_ASSERT_NXT(a_reply_strobe, cmd_i.reply, valid_o)
  // Kept children never outnumber loaded voxels
  `VLC_ASSERT_IMP(a_children_bounded, 1'b1, ctot_q <= CTOT_W'(vidx_q))
  // Read position stays inside a loaded, non-empty chunk
  `VLC_ASSERT_IMP(a_read_in_range, loaded && (ptot_q != '0), ridx_q < total)

endmodule

`default_nettype wire

/* test/voxel_layer_compactor_test.sv */
// Self-checking testbench of the voxel layer compactor: loads voxel chunks,
// reads back parent and child words and checks them against its own predictor.
// Depends on vlc_pkg and voxel_layer_compactor.
`default_nettype none

module voxel_layer_compactor_test
  import vlc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHUNK_EDGE     = VLC_CHUNK_EDGE_DEF;
  localparam int VOXELS         = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int GROUPS         = (VOXELS + VLC_GROUP_SIZE - 1) / VLC_GROUP_SIZE;
  localparam int ITEM_TARGET    = 1900;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;

  typedef struct {
    logic [VLC_WORD_W-1:0] word;
    logic                  last;
    status_e               status;
  } voxel_reply_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   start   = 1'b0;
  logic                   busy;
  func_e                  func_i  = FUNC_LOAD;
  logic [VLC_VOXEL_W-1:0] voxel_i = '0;
  logic                   result_valid_o;
  logic [VLC_WORD_W-1:0]  word_o;
  logic                   last_o;
  logic [1:0]             status_o;

  voxel_layer_compactor #(.CHUNK_EDGE(CHUNK_EDGE)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .voxel_i       (voxel_i),
    .result_valid_o(result_valid_o),
    .word_o        (word_o),
    .last_o        (last_o),
    .status_o      (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: compacted chunk as the block should hold it
  logic [VLC_VOXEL_W-1:0] kept_voxels [VOXELS];
  logic [VLC_MASK_W-1:0]  group_mask_mem [GROUPS];
  logic [VLC_GCNT_W-1:0]  group_count_mem [GROUPS];
  logic [VLC_MASK_W-1:0]  open_mask;
  logic [VLC_GCNT_W-1:0]  open_children;
  logic [VLC_PTR_W-1:0]   ptr_accum;
  int                     load_pos;
  int                     parent_cnt;
  int                     child_cnt;
  int                     read_pos;

  voxel_reply_t reply_q[$];

  int errors        = 0;
  int items_sent    = 0;
  int loads_sent    = 0;
  int reads_sent    = 0;
  int chunks_done   = 0;
  int words_checked = 0;
  int unloaded_seen = 0;
  int empty_seen    = 0;
  int idle_cycles   = 0;

  // Sender pacing
  bit sender_idles = 1'b0;
  int burst_left   = 0;

  function automatic void clear_chunk_state();
    open_mask     = '0;
    open_children = '0;
    ptr_accum     = '0;
    load_pos      = 0;
    parent_cnt    = 0;
    child_cnt     = 0;
    read_pos      = 0;
  endfunction

  // Fold one voxel into the open group; close the group at its end or the chunk's
  function automatic void absorb_voxel(logic [VLC_VOXEL_W-1:0] v);
    if (load_pos >= VOXELS) begin
      clear_chunk_state();
    end
    if (v != '0) begin
      open_mask[load_pos % VLC_GROUP_SIZE] = 1'b1;
      if (child_cnt < VOXELS) begin
        kept_voxels[child_cnt] = v;
      end
      child_cnt++;
      open_children++;
    end
    if ((load_pos % VLC_GROUP_SIZE) == VLC_GROUP_SIZE - 1 || load_pos + 1 == VOXELS) begin
      if (open_mask != '0 && parent_cnt < GROUPS) begin
        group_mask_mem[parent_cnt]  = open_mask;
        group_count_mem[parent_cnt] = open_children;
        parent_cnt++;
      end
      open_mask     = '0;
      open_children = '0;
    end
    load_pos++;
    if (load_pos == VOXELS) begin
      chunks_done++;
    end
  endfunction

  // Next output word of the compacted chunk, or a status reply
  function automatic voxel_reply_t next_layer_word();
    voxel_reply_t r;
    int           total;
    logic [VLC_PTR_W-1:0] ptr;
    r.word   = '0;
    r.last   = 1'b0;
    r.status = STATUS_OK;
    total    = parent_cnt + child_cnt;
    if (load_pos < VOXELS) begin
      r.status = STATUS_NOT_LOADED;
    end else if (parent_cnt == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      if (read_pos >= total) begin
        read_pos  = 0;
        ptr_accum = '0;
      end
      if (read_pos < parent_cnt) begin
        ptr       = VLC_PTR_W'(parent_cnt) + ptr_accum;
        r.word    = {ptr, group_mask_mem[read_pos]};
        ptr_accum = ptr_accum + VLC_PTR_W'(group_count_mem[read_pos]);
      end else if (read_pos - parent_cnt < VOXELS) begin
        r.word = {8'h00, kept_voxels[read_pos - parent_cnt]};
      end
      r.last = (read_pos + 1 == total);
      read_pos++;
      if (r.last) begin
        read_pos  = 0;
        ptr_accum = '0;
      end
    end
    return r;
  endfunction

  // Send one transaction, honouring the burst and gap pattern of the sender
  task automatic send_item(func_e f, logic [VLC_VOXEL_W-1:0] v);
    int gap;
    if (sender_idles && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    start   <= 1'b1;
    func_i  <= f;
    voxel_i <= v;
    do @(posedge clk_i); while (busy);
    // Accepted at this edge: advance the predictor
    items_sent++;
    if (f == FUNC_READ) begin
      reads_sent++;
      reply_q.push_back(next_layer_word());
    end else begin
      loads_sent++;
      absorb_voxel(v);
    end
  endtask

  task automatic load_voxel(logic [VLC_VOXEL_W-1:0] v);
    send_item(FUNC_LOAD, v);
  endtask

  task automatic read_words(int n);
    repeat (n) send_item(FUNC_READ, '0);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    voxel_reply_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result: word %h last %b status %0d", word_o, last_o, status_o);
        errors++;
      end else begin
        exp_r = reply_q.pop_front();
        if (word_o !== exp_r.word) begin
          $error("word: expected %h, actual %h", exp_r.word, word_o);
          errors++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %b, actual %b", exp_r.last, last_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          errors++;
        end
        case (exp_r.status)
          STATUS_NOT_LOADED: unloaded_seen++;
          STATUS_EMPTY:      empty_seen++;
          default:           words_checked++;
        endcase
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reads straight after reset and during a partial load
  task automatic test_unloaded_reads();
    read_words(2);
    repeat (10) load_voxel(8'h00);
    read_words(1);
  endtask

  // Finish the chunk with empty voxels only
  task automatic test_empty_chunk();
    repeat (VOXELS - 10) load_voxel(8'h00);
    read_words(2);
  endtask

  // Every voxel occupied, extremes first; read past the end to see the wrap
  task automatic test_full_chunk();
    logic [VLC_VOXEL_W-1:0] v;
    for (int i = 0; i < VOXELS; i++) begin
      case (i)
        0:       v = 8'hFF;
        1:       v = 8'h01;
        2:       v = 8'h80;
        3:       v = 8'h7F;
        default: v = VLC_VOXEL_W'(i * 37) | 8'h01;
      endcase
      load_voxel(v);
    end
    read_words(parent_cnt + child_cnt + 3);
  endtask

  // Sparse chunk, read cut short, then a new chunk started mid-read
  task automatic test_sparse_restart();
    logic [VLC_VOXEL_W-1:0] v;
    for (int i = 0; i < VOXELS; i++) begin
      v = (i == 7 || i == VOXELS - 1) ? 8'hA5 :
          (i >= 24 && i < 32 && i[0]) ? VLC_VOXEL_W'(i) : 8'h00;
      load_voxel(v);
    end
    read_words(2);
    for (int i = 0; i < VOXELS; i++) begin
      load_voxel((i % 3 == 0) ? VLC_VOXEL_W'($urandom_range(1, 255)) : 8'h00);
    end
    read_words(parent_cnt + child_cnt);
  endtask

  // Well-formed chunks of random density, with stray reads and cut-short reads
  task automatic test_random_chunks();
    int density;
    int n_reads;
    int total;
    logic [VLC_VOXEL_W-1:0] v;
    while (items_sent < ITEM_TARGET) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       density = 0;
        1:       density = 5;
        2:       density = 30;
        3:       density = 60;
        4:       density = 90;
        default: density = 100;
      endcase
      for (int i = 0; i < VOXELS; i++) begin
        if ($urandom_range(0, 99) < 3) begin
          read_words(1);
        end
        v = ($urandom_range(1, 100) <= density) ? VLC_VOXEL_W'($urandom_range(1, 255)) : 8'h00;
        load_voxel(v);
      end
      total = parent_cnt + child_cnt;
      case ($urandom_range(0, 9))
        0:       n_reads = 0;
        1, 2:    n_reads = $urandom_range(1, total + 1);
        3:       n_reads = total + $urandom_range(1, 6);
        default: n_reads = total;
      endcase
      read_words(n_reads);
    end
  endtask

  initial begin
    clear_chunk_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unloaded_reads();
    test_empty_chunk();
    test_full_chunk();
    test_sparse_restart();
    test_random_chunks();

    // Drain outstanding results, then allow for the read latency
    start <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d loads and %0d reads over %0d complete chunks.",
             loads_sent, reads_sent, chunks_done);
    $display("Checked %0d layer words, %0d not-loaded and %0d empty-chunk replies.",
             words_checked, unloaded_seen, empty_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
